@@ sv/npl_pkg.sv @@
// Shared types, constants and helpers for the note priority list.
// Used by the channel interfaces, the list cells, the controller and the top level.
// No dependencies.
package npl_pkg;

	localparam int NPL_LIST_DEPTH = 16;

	localparam int PITCH_W    = 7;
	localparam int VEL_W      = 7;
	localparam int MODE_W     = 2;
	localparam int VOICE_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// event opcodes
	localparam logic OP_ON  = 1'b0;
	localparam logic OP_OFF = 1'b1;

	// priority modes
	localparam logic [MODE_W-1:0] MODE_NEWEST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HIGHEST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOWEST  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOICES    = 1'd1;

	// one list slot
	typedef struct packed {
		logic               valid;
		logic [PITCH_W-1:0] pitch;
		logic [VEL_W-1:0]   vel;
	} entry_t;

	// beat that walks down the chain, one cell per cycle
	typedef struct packed {
		logic               act;
		logic               op;
		logic [PITCH_W-1:0] pitch;
		logic [VEL_W-1:0]   vel;
		logic [VOICE_W-1:0] left;      // voice slots still ahead of this cell
		logic               placed;    // new note already stored
		entry_t             car;       // entry pushed down by an insert
		logic               sounded;
		logic               lim_hit;   // last sounding slot is occupied
		logic               old_pend;  // next cell is the first silent slot
		logic               old_valid;
		logic [PITCH_W-1:0] old_pitch;
		entry_t             cap;       // note promoted by a note-off
	} wave_t;

	typedef struct packed {
		logic               new_valid;
		logic [PITCH_W-1:0] new_pitch;
		logic [VEL_W-1:0]   new_velocity;
		logic               old_valid;
		logic [PITCH_W-1:0] old_pitch;
		logic               dropped;
	} result_t;

	// true when a new pitch goes ahead of a stored one
	function automatic logic beats(input logic [MODE_W-1:0] mode,
			input logic [PITCH_W-1:0] newp, input logic [PITCH_W-1:0] oldp);
		logic r;
		unique case (mode)
			MODE_NEWEST:  r = 1'b1;
			MODE_HIGHEST: r = (newp > oldp);
			MODE_LOWEST:  r = (newp < oldp);
			default:      r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/npl_note_in_if.sv @@
// Input event channel of the note priority list.
// Depends on npl_pkg for field widths.
interface npl_note_in_if import npl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [PITCH_W-1:0] pitch;
	logic [VEL_W-1:0]   velocity;

	modport source (output valid, op, pitch, velocity, input ready);
	modport sink   (input valid, op, pitch, velocity, output ready);
endinterface

@@ sv/npl_note_out_if.sv @@
// Result channel of the note priority list.
// Depends on npl_pkg for field widths.
interface npl_note_out_if import npl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               new_valid;
	logic [PITCH_W-1:0] new_pitch;
	logic [VEL_W-1:0]   new_velocity;
	logic               old_valid;
	logic [PITCH_W-1:0] old_pitch;
	logic               dropped;

	modport source (output valid, new_valid, new_pitch, new_velocity, old_valid, old_pitch,
		dropped, input ready);
	modport sink   (input valid, new_valid, new_pitch, new_velocity, old_valid, old_pitch,
		dropped, output ready);
endinterface

@@ sv/npl_cfg_if.sv @@
// Configuration write channel of the note priority list.
// Depends on npl_pkg for index and data widths.
interface npl_cfg_if import npl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/npl_cell.sv @@
// One slot of the note list: holds an entry, processes the passing beat, and
// shifts entries toward the front during compaction. Depends on npl_pkg.
module npl_cell import npl_pkg::*; #(
	parameter bit IS_LAST = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode,
	input  logic              cmp_en,
	input  wave_t             wave_in,
	input  entry_t            nb_ent,
	input  logic              prev_valid,
	output wave_t             wave_out,
	output entry_t            ent
);

	logic               valid_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [VEL_W-1:0]   vel_q;
	wave_t              wave_q;
	wave_t              wave_d;
	entry_t             ent_d;

	assign ent = '{valid: valid_q, pitch: pitch_q, vel: vel_q};

	// work out the new slot content and the beat handed to the next cell
	always_comb begin
		entry_t fin;
		entry_t wdat;
		logic   take_new;
		logic   take_car;
		logic   match;

		wave_d   = wave_in;
		fin      = ent;
		take_new = !wave_in.placed && (!ent.valid || IS_LAST ||
			beats(mode, wave_in.pitch, ent.pitch));
		take_car = wave_in.placed && wave_in.car.valid;
		wdat     = take_new ? entry_t'{valid: 1'b1, pitch: wave_in.pitch, vel: wave_in.vel}
			: wave_in.car;
		match    = ent.valid && (ent.pitch == wave_in.pitch);

		if (wave_in.act) begin
			if (wave_in.op == OP_ON) begin
				// insert or push down, then score the final slot content
				if (take_new || take_car) begin
					fin        = wdat;
					wave_d.car = ent;
				end
				wave_d.placed  = wave_in.placed | take_new;
				wave_d.sounded = wave_in.sounded | ((wave_in.left != '0) && fin.valid &&
					(fin.pitch == wave_in.pitch));
				wave_d.lim_hit = wave_in.lim_hit | ((wave_in.left == VOICE_W'(1)) && fin.valid);
				if (wave_in.old_pend) begin
					wave_d.old_valid = fin.valid;
					wave_d.old_pitch = fin.valid ? fin.pitch : '0;
				end
				wave_d.old_pend = (wave_in.left == VOICE_W'(1));
				if (wave_in.left != '0)
					wave_d.left = wave_in.left - VOICE_W'(1);
			end else begin
				// drop matching pitch, count kept entries toward the last voice
				if (match) begin
					fin.valid = 1'b0;
				end else if (ent.valid) begin
					if (wave_in.left == VOICE_W'(1))
						wave_d.cap = ent;
					if (wave_in.left != '0)
						wave_d.left = wave_in.left - VOICE_W'(1);
				end
			end
		end else if (cmp_en) begin
			// pull the right neighbor into a hole, vacate when the left is a hole
			if (!ent.valid)
				fin = nb_ent;
			else if (!prev_valid)
				fin.valid = 1'b0;
		end
		ent_d = fin;
	end

	// hold occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= ent_d.valid;
	end

	// hold entry payload
	always_ff @(posedge clk) begin
		pitch_q <= ent_d.pitch;
		vel_q   <= ent_d.vel;
	end

	// advance the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wave_q <= '0;
		else
			wave_q <= wave_d;
	end

	assign wave_out = wave_q;

endmodule

@@ sv/npl_ctrl.sv @@
// Sequencer of the note priority list: config registers, event launch,
// compaction sweep and the result register. Depends on npl_pkg and the channel interfaces.
module npl_ctrl import npl_pkg::*; #(
	parameter int LIST_DEPTH = NPL_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	npl_note_in_if.sink       note_in,
	npl_note_out_if.source    note_out,
	npl_cfg_if.sink           cfg,
	output logic [MODE_W-1:0] mode,
	output logic              cmp_en,
	output wave_t             wave_first,
	input  wave_t             wave_last
);

	localparam int CW = (LIST_DEPTH > 2) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAVE = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [MODE_W-1:0]  mode_q;
	logic [VOICE_W-1:0] mv_q;
	wave_t              wave0_q;
	wave_t              seed;
	result_t            res_d;
	result_t            res_q;
	result_t            out_q;
	logic               out_valid_q;
	logic               in_acc;
	logic               out_acc;
	logic               out_load;

	assign in_acc    = note_in.valid && note_in.ready;
	assign out_acc   = note_out.valid && note_out.ready;
	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || note_out.ready);
	assign note_in.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmp_en    = (state_q == ST_CMP);
	assign mode      = mode_q;
	assign wave_first = wave0_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			mv_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PRIORITY_MODE: mode_q <= cfg.data[MODE_W-1:0];
				REG_MAX_VOICES:    mv_q   <= cfg.data[VOICE_W-1:0];
			endcase
		end
	end

	// beat launched into the first cell
	always_comb begin
		seed        = '0;
		seed.act    = 1'b1;
		seed.op     = note_in.op;
		seed.pitch  = note_in.pitch;
		seed.vel    = note_in.velocity;
		seed.left   = mv_q;
	end

	// result from the beat leaving the last cell
	always_comb begin
		res_d = '0;
		if (wave_last.op == OP_ON) begin
			res_d.dropped = wave_last.car.valid;
			if (!(wave_last.lim_hit && !wave_last.sounded)) begin
				res_d.new_valid    = 1'b1;
				res_d.new_pitch    = wave_last.pitch;
				res_d.new_velocity = wave_last.vel;
				res_d.old_valid    = wave_last.lim_hit && wave_last.old_valid;
				res_d.old_pitch    = res_d.old_valid ? wave_last.old_pitch : '0;
			end
		end else begin
			res_d.new_valid    = wave_last.cap.valid;
			res_d.new_pitch    = wave_last.cap.pitch;
			res_d.new_velocity = wave_last.cap.vel;
		end
	end

	// launch a beat for one cycle on an accepted event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wave0_q <= '0;
		else
			wave0_q <= in_acc ? seed : '0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_WAVE;
				end
				ST_WAVE: begin
					if (wave_last.act) begin
						cnt_q   <= CW'(LIST_DEPTH - 1);
						state_q <= (wave_last.op == OP_OFF) ? ST_CMP : ST_HOLD;
					end
				end
				ST_CMP: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the result as the beat comes back
	always_ff @(posedge clk) begin
		if (state_q == ST_WAVE && wave_last.act)
			res_q <= res_d;
		if (out_load)
			out_q <= res_q;
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	assign note_out.valid        = out_valid_q;
	assign note_out.new_valid    = out_q.new_valid;
	assign note_out.new_pitch    = out_q.new_pitch;
	assign note_out.new_velocity = out_q.new_velocity;
	assign note_out.old_valid    = out_q.old_valid;
	assign note_out.old_pitch    = out_q.old_pitch;
	assign note_out.dropped      = out_q.dropped;

	a_ret_in_wave: assert property (@(posedge clk) disable iff (!arst_n)
		wave_last.act |-> state_q == ST_WAVE)
		else $error("beat left the chain outside the walk");

	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> wave0_q.act && state_q == ST_WAVE)
		else $error("accepted event did not launch a beat");

	a_cmp_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> !wave0_q.act && !wave_last.act)
		else $error("compaction overlaps a beat");

	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_HOLD)
		else $error("result raised outside the hold state");

endmodule

@@ sv/note_priority_list.sv @@
// Note priority list: chain of LIST_DEPTH cells, one beat walks one cell per cycle.
// Note-on: the result goes out once the beat has walked every cell and passed through res_q.
// Note-off: the walk is followed by a compaction sweep over the cells before the result goes out.
// Next event taken the cycle after the result enters the output register, so only one event
// is in flight at a time; an unread result holds the next one back.
// Reset empties every cell and clears priority_mode and max_voices to 0.
module note_priority_list import npl_pkg::*; #(
	parameter int LIST_DEPTH = NPL_LIST_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	npl_note_in_if.sink    note_in,
	npl_note_out_if.source note_out,
	npl_cfg_if.sink        cfg
);

	logic [MODE_W-1:0] mode;
	logic              cmp_en;
	wave_t             wv  [0:LIST_DEPTH];
	entry_t            ent [0:LIST_DEPTH-1];

	npl_ctrl #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.note_in    (note_in),
		.note_out   (note_out),
		.cfg        (cfg),
		.mode       (mode),
		.cmp_en     (cmp_en),
		.wave_first (wv[0]),
		.wave_last  (wv[LIST_DEPTH])
	);

	// row of list cells, front at index 0
	for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
		entry_t nb_ent;
		logic   prev_valid;

		if (gi < LIST_DEPTH - 1) begin : g_nb
			assign nb_ent = ent[gi+1];
		end else begin : g_nb_end
			assign nb_ent = '0;
		end

		if (gi > 0) begin : g_pv
			assign prev_valid = ent[gi-1].valid;
		end else begin : g_pv_head
			assign prev_valid = 1'b1;
		end

		npl_cell #(
			.IS_LAST (1'(gi == LIST_DEPTH - 1))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.mode       (mode),
			.cmp_en     (cmp_en),
			.wave_in    (wv[gi]),
			.nb_ent     (nb_ent),
			.prev_valid (prev_valid),
			.wave_out   (wv[gi+1]),
			.ent        (ent[gi])
		);
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench for note_priority_list: directed and random note events against a built-in list predictor.
// Depends on npl_pkg, the three channel interfaces and the note_priority_list top level.
module tb import npl_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// mode with no winning comparison: new notes go to the tail
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd3;
	localparam int SETTLE_CYCLES = 2 * NPL_LIST_DEPTH + 8;

	logic clk = 1'b0;
	logic arst_n;

	npl_note_in_if  note_in_ch();
	npl_note_out_if note_out_ch();
	npl_cfg_if      cfg_ch();

	note_priority_list u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.note_in  (note_in_ch),
		.note_out (note_out_ch),
		.cfg      (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predicted list contents and register copies
	logic [PITCH_W-1:0] held_pitch [NPL_LIST_DEPTH];
	logic [VEL_W-1:0]   held_vel   [NPL_LIST_DEPTH];
	int                 held_total = 0;
	logic [MODE_W-1:0]  cur_mode   = MODE_NEWEST;
	logic [VOICE_W-1:0] cur_voices = '0;

	result_t pending_results [$];
	int      fail_count = 0;
	int      burst_left = 0;

	// true when the new pitch takes a place ahead of the stored one
	function automatic logic note_outranks(logic [PITCH_W-1:0] newp, logic [PITCH_W-1:0] oldp);
		case (cur_mode)
			MODE_NEWEST:  return 1'b1;
			MODE_HIGHEST: return newp > oldp;
			MODE_LOWEST:  return newp < oldp;
			default:      return 1'b0;
		endcase
	endfunction

	// update the held list for one event and return the voice change it causes
	function automatic result_t predict_event(logic op, logic [PITCH_W-1:0] p,
			logic [VEL_W-1:0] v);
		result_t r;
		int      pos;
		int      w;
		logic    sounded;
		r = '0;
		sounded = 1'b0;
		if (op == OP_ON) begin
			// make room by dropping the tail
			if (held_total >= NPL_LIST_DEPTH) begin
				held_total = NPL_LIST_DEPTH - 1;
				r.dropped = 1'b1;
			end
			pos = held_total;
			for (int i = 0; i < held_total; i++) begin
				if (note_outranks(p, held_pitch[i])) begin
					pos = i;
					break;
				end
			end
			for (int i = held_total; i > pos; i--) begin
				held_pitch[i] = held_pitch[i-1];
				held_vel[i]   = held_vel[i-1];
			end
			held_pitch[pos] = p;
			held_vel[pos]   = v;
			held_total++;
			r.new_valid    = 1'b1;
			r.new_pitch    = p;
			r.new_velocity = v;
			// walk to the last sounding slot
			for (int i = 0; i < held_total; i++) begin
				if (held_pitch[i] == p)
					sounded = 1'b1;
				if (cur_voices != 0 && i + 1 >= cur_voices) begin
					if (!sounded) begin
						r.new_valid    = 1'b0;
						r.new_pitch    = '0;
						r.new_velocity = '0;
					end else if (i + 1 < held_total) begin
						r.old_valid = 1'b1;
						r.old_pitch = held_pitch[i+1];
					end
					break;
				end
			end
		end else begin
			// compact out every entry of this pitch
			w = 0;
			for (int i = 0; i < held_total; i++) begin
				if (held_pitch[i] != p) begin
					held_pitch[w] = held_pitch[i];
					held_vel[w]   = held_vel[i];
					w++;
				end
			end
			held_total = w;
			if (cur_voices != 0 && held_total >= cur_voices) begin
				r.new_valid    = 1'b1;
				r.new_pitch    = held_pitch[cur_voices-1];
				r.new_velocity = held_vel[cur_voices-1];
			end
		end
		return r;
	endfunction

	// send one event beat; bursts of random length with random gaps between them
	task automatic send_event(logic op, logic [PITCH_W-1:0] p, logic [VEL_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap != 0) begin
				note_in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		note_in_ch.valid    <= 1'b1;
		note_in_ch.op       <= op;
		note_in_ch.pitch    <= p;
		note_in_ch.velocity <= v;
		do @(posedge clk); while (!(note_in_ch.valid && note_in_ch.ready));
		pending_results.push_back(predict_event(op, p, v));
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_drained();
		note_in_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// present one register write and hold it until accepted
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		if (idx == REG_PRIORITY_MODE)
			cur_mode = val[MODE_W-1:0];
		else
			cur_voices = val[VOICE_W-1:0];
	endtask

	task automatic set_regs(logic [MODE_W-1:0] mode, logic [VOICE_W-1:0] voices);
		wait_drained();
		write_reg(REG_PRIORITY_MODE, CFG_DATA_W'(mode));
		write_reg(REG_MAX_VOICES, CFG_DATA_W'(voices));
		cfg_ch.valid <= 1'b0;
	endtask

	// reset defaults: newest first, unlimited voices, extremes, unheld and empty-list note-offs
	task automatic test_reset_defaults();
		send_event(OP_ON, 7'd0, 7'd0);
		send_event(OP_ON, 7'd127, 7'd127);
		send_event(OP_ON, 7'd127, 7'd1);
		send_event(OP_OFF, 7'd5, 7'd0);
		send_event(OP_OFF, 7'd127, 7'd33);
		send_event(OP_OFF, 7'd0, 7'd0);
		send_event(OP_OFF, 7'd0, 7'd127);
	endtask

	// two voices in highest mode: displacement, beyond-limit note, promotion, tail mode
	task automatic test_voice_limit();
		set_regs(MODE_HIGHEST, 5'd2);
		send_event(OP_ON, 7'd60, 7'd10);
		send_event(OP_ON, 7'd70, 7'd20);
		send_event(OP_ON, 7'd50, 7'd30);
		send_event(OP_ON, 7'd80, 7'd40);
		send_event(OP_OFF, 7'd80, 7'd0);
		set_regs(MODE_APPEND, 5'd2);
		send_event(OP_ON, 7'd90, 7'd5);
	endtask

	// fill the list in lowest mode at sixteen voices until the tail drops
	task automatic test_full_list();
		set_regs(MODE_LOWEST, 5'd16);
		for (int i = 0; i < 13; i++)
			send_event(OP_ON, 7'(100 + i), 7'(i * 9));
	endtask

	// random events: note-offs mostly of held pitches, note-ons with some repeats
	task automatic test_random_traffic();
		logic [MODE_W-1:0]  phase_mode   [9] = '{MODE_NEWEST, MODE_HIGHEST, MODE_LOWEST,
			MODE_HIGHEST, MODE_NEWEST, MODE_LOWEST, MODE_APPEND, MODE_HIGHEST, MODE_LOWEST};
		logic [VOICE_W-1:0] phase_voices [9] = '{5'd0, 5'd16, 5'd1, 5'd3, 5'd8, 5'd0,
			5'd4, 5'd15, 5'd6};
		int                 phase_on_pct [9] = '{55, 65, 60, 70, 50, 75, 60, 65, 58};
		logic               op;
		logic [PITCH_W-1:0] p;
		for (int ph = 0; ph < 9; ph++) begin
			set_regs(phase_mode[ph], phase_voices[ph]);
			for (int n = 0; n < 117; n++) begin
				if (held_total == 0 || $urandom_range(0, 99) < phase_on_pct[ph]) begin
					op = OP_ON;
					if (held_total != 0 && $urandom_range(0, 3) == 0)
						p = held_pitch[$urandom_range(0, held_total - 1)];
					else
						p = 7'($urandom_range(0, 127));
				end else begin
					op = OP_OFF;
					if ($urandom_range(0, 6) != 0)
						p = held_pitch[$urandom_range(0, held_total - 1)];
					else
						p = 7'($urandom_range(0, 127));
				end
				send_event(op, p, 7'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		note_in_ch.valid    <= 1'b0;
		note_in_ch.op       <= OP_ON;
		note_in_ch.pitch    <= '0;
		note_in_ch.velocity <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_PRIORITY_MODE;
		cfg_ch.data         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_voice_limit();
		test_full_list();
		test_random_traffic();

		wait_drained();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// result ready: switch between free flow, random, sparse and periodic stalls
	int unsigned stall_left  = 0;
	int          stall_style = 0;

	initial note_out_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left  <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0:       note_out_ch.ready <= 1'b1;
			1:       note_out_ch.ready <= $urandom_range(0, 1);
			2:       note_out_ch.ready <= ($urandom_range(0, 4) == 0);
			default: note_out_ch.ready <= ((stall_left % 16) < 8);
		endcase
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && note_out_ch.valid && note_out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no event outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("new_valid", want.new_valid, note_out_ch.new_valid);
				check_field("new_pitch", want.new_pitch, note_out_ch.new_pitch);
				check_field("new_velocity", want.new_velocity, note_out_ch.new_velocity);
				check_field("old_valid", want.old_valid, note_out_ch.old_valid);
				check_field("old_pitch", want.old_pitch, note_out_ch.old_pitch);
				check_field("dropped", want.dropped, note_out_ch.dropped);
			end
		end
	end

endmodule
